FILE: hdl/vbat_pkg.sv
// Shared constants for the voxel block average/threshold design.
// Field widths, configuration register codes and reset values.
// No dependencies; every other file imports this package.
package vbat_pkg;

	localparam int VOXEL_W   = 8;
	localparam int SUM_W     = 20;
	localparam int COORD_W   = 7;
	localparam int AVG_W     = 16;
	localparam int FRAC_W    = 8;
	localparam int DIM_REG_W = 8;
	localparam int BF_REG_W  = 5;
	localparam int THR_W     = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 8'd128;
	localparam logic [BF_REG_W-1:0]  BF_RESET  = 5'd4;
	localparam logic [THR_W-1:0]     THR_RESET = 8'd0;

endpackage

FILE: hdl/vbat_if.sv
// Stream interfaces for the voxel input and the cube result channels.
// Depends on vbat_pkg for the payload widths.
interface vbat_voxel_if import vbat_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VOXEL_W-1:0] voxel_value;

	modport source (output valid, output voxel_value, input ready);
	modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vbat_cube_if import vbat_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] origin_x;
	logic [COORD_W-1:0] origin_y;
	logic [COORD_W-1:0] origin_z;
	logic [AVG_W-1:0]   average_q8;

	modport source (output valid, output origin_x, output origin_y, output origin_z,
		output average_q8, input ready);
	modport sink   (input valid, input origin_x, input origin_y, input origin_z,
		input average_q8, output ready);
endinterface

FILE: hdl/vbat_front.sv
// Front end: raster counters, cube classification and queue entry packing.
// Depends on vbat_pkg and vbat_voxel_if.
module vbat_front import vbat_pkg::*; #(
	parameter int MAX_SIDE  = 128,
	parameter int MAX_BLOCK = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  logic [$clog2(MAX_SIDE+1)-1:0] side_w,
	input  logic [$clog2(MAX_SIDE+1)-1:0] side_h,
	input  logic [$clog2(MAX_SIDE+1)-1:0] side_d,
	input  logic [$clog2(MAX_BLOCK+1)-1:0] bf,
	vbat_voxel_if.sink voxels,
	output logic push_valid,
	input  logic push_ready,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)+2+VOXEL_W+3*COORD_W+3*$clog2(MAX_BLOCK+1)-1:0]
		push_data
);
	localparam int POS_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE+1);
	localparam int BLK_W  = $clog2(MAX_BLOCK+1);
	localparam int OFF_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
	localparam int CMP_W  = (SIDE_W > BLK_W) ? SIDE_W : BLK_W;

	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [OFF_W-1:0] off_x_q, off_y_q, off_z_q;
	logic [POS_W-1:0] bx_q, by_q;

	logic              accept;
	logic [POS_W-1:0]  org_x, org_y, org_z;
	logic [SIDE_W-1:0] rem_x, rem_y, rem_z;
	logic [BLK_W-1:0]  cx, cy, cz;
	logic [SIDE_W-1:0] px_inc, py_inc, pz_inc;
	logic [BLK_W-1:0]  ox_inc, oy_inc, oz_inc;
	logic              wrap_x, wrap_y, wrap_z;
	logic              bend_x, bend_y, bend_z;
	logic              first, last;
	logic [ADDR_W-1:0] slot;

	assign accept       = voxels.valid && push_ready;
	assign voxels.ready = push_ready;
	assign push_valid   = voxels.valid;

	// Origin of the current cube and its size after clipping at the far faces.
	assign org_x = pos_x_q - POS_W'(off_x_q);
	assign org_y = pos_y_q - POS_W'(off_y_q);
	assign org_z = pos_z_q - POS_W'(off_z_q);
	assign rem_x = side_w - SIDE_W'(org_x);
	assign rem_y = side_h - SIDE_W'(org_y);
	assign rem_z = side_d - SIDE_W'(org_z);
	assign cx = (CMP_W'(rem_x) < CMP_W'(bf)) ? BLK_W'(rem_x) : bf;
	assign cy = (CMP_W'(rem_y) < CMP_W'(bf)) ? BLK_W'(rem_y) : bf;
	assign cz = (CMP_W'(rem_z) < CMP_W'(bf)) ? BLK_W'(rem_z) : bf;

	assign ox_inc = BLK_W'(off_x_q) + BLK_W'(1);
	assign oy_inc = BLK_W'(off_y_q) + BLK_W'(1);
	assign oz_inc = BLK_W'(off_z_q) + BLK_W'(1);
	assign px_inc = SIDE_W'(pos_x_q) + SIDE_W'(1);
	assign py_inc = SIDE_W'(pos_y_q) + SIDE_W'(1);
	assign pz_inc = SIDE_W'(pos_z_q) + SIDE_W'(1);
	assign wrap_x = px_inc >= side_w;
	assign wrap_y = py_inc >= side_h;
	assign wrap_z = pz_inc >= side_d;
	assign bend_x = ox_inc == bf;
	assign bend_y = oy_inc == bf;
	assign bend_z = oz_inc == bf;

	assign first = (off_x_q == '0) && (off_y_q == '0) && (off_z_q == '0);
	assign last  = (ox_inc == cx) && (oy_inc == cy) && (oz_inc == cz);
	assign slot  = ADDR_W'(by_q) * ADDR_W'(MAX_SIDE) + ADDR_W'(bx_q);

	assign push_data = {slot, first, last, voxels.voxel_value,
		COORD_W'(org_x), COORD_W'(org_y), COORD_W'(org_z), cx, cy, cz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			bx_q    <= '0;
			by_q    <= '0;
		end else if (restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			bx_q    <= '0;
			by_q    <= '0;
		end else if (accept) begin
			if (wrap_x) begin
				pos_x_q <= '0;
				off_x_q <= '0;
				bx_q    <= '0;
				if (wrap_y) begin
					pos_y_q <= '0;
					off_y_q <= '0;
					by_q    <= '0;
					if (wrap_z) begin
						pos_z_q <= '0;
						off_z_q <= '0;
					end else begin
						pos_z_q <= POS_W'(pz_inc);
						off_z_q <= bend_z ? '0 : OFF_W'(oz_inc);
					end
				end else begin
					pos_y_q <= POS_W'(py_inc);
					off_y_q <= bend_y ? '0 : OFF_W'(oy_inc);
					by_q    <= bend_y ? by_q + POS_W'(1) : by_q;
				end
			end else begin
				pos_x_q <= POS_W'(px_inc);
				off_x_q <= bend_x ? '0 : OFF_W'(ox_inc);
				bx_q    <= bend_x ? bx_q + POS_W'(1) : bx_q;
			end
		end
	end

	a_offset_in_cube: assert property (@(posedge clk) disable iff (!arst_n)
		(BLK_W'(off_x_q) < bf) && (BLK_W'(off_y_q) < bf) && (BLK_W'(off_z_q) < bf))
		else $error("cube offset reached the block factor");
	a_pos_in_volume: assert property (@(posedge clk) disable iff (!arst_n)
		(SIDE_W'(pos_x_q) < side_w) && (SIDE_W'(pos_y_q) < side_h)
		&& (SIDE_W'(pos_z_q) < side_d))
		else $error("raster position outside the volume");

endmodule

FILE: hdl/vbat_queue.sv
// Small register FIFO that decouples the front end from the accumulator.
// Depends on vbat_pkg for the default depth.
module vbat_queue import vbat_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [W-1:0]     entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above its depth");

endmodule

FILE: hdl/vbat_accum.sv
// Back end accumulator: read-modify-write of the partial sum slab with forwarding.
// Depends on vbat_pkg; feeds completed cubes to vbat_finish.
module vbat_accum import vbat_pkg::*; #(
	parameter int MAX_SIDE  = 128,
	parameter int MAX_BLOCK = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  logic [$clog2(MAX_SIDE*MAX_SIDE)+2+VOXEL_W+3*COORD_W+3*$clog2(MAX_BLOCK+1)-1:0]
		q_data,
	output logic fin_valid,
	input  logic fin_ready,
	output logic [SUM_W+3*COORD_W+3*$clog2(MAX_BLOCK+1)-1:0] fin_data
);
	localparam int BLK_W  = $clog2(MAX_BLOCK+1);
	localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
	localparam int TAIL_W = 3*COORD_W + 3*BLK_W;
	localparam int QW     = ADDR_W + 2 + VOXEL_W + TAIL_W;
	localparam int SLOTS  = MAX_SIDE*MAX_SIDE;

	logic [SUM_W-1:0]  mem [SLOTS];
	logic [SUM_W-1:0]  rdata_q;
	logic [QW-1:0]     data_s2;
	logic              valid_s2;
	logic              fwd_q;
	logic [SUM_W-1:0]  fwd_sum_q;

	logic [ADDR_W-1:0]  q_slot, slot_s2;
	logic               first_s2, last_s2;
	logic [VOXEL_W-1:0] value_s2;
	logic [TAIL_W-1:0]  tail_s2;
	logic [SUM_W-1:0]   operand, sum;
	logic               adv, pop;

	assign q_slot = q_data[QW-1 -: ADDR_W];
	assign {slot_s2, first_s2, last_s2, value_s2, tail_s2} = data_s2;

	// A voxel leaves this stage unless it completes a cube the finisher cannot take yet.
	assign adv     = valid_s2 && (!last_s2 || fin_ready);
	assign pop     = q_valid && (!valid_s2 || adv);
	assign q_ready = !valid_s2 || adv;

	// The memory reads the old value when the previous voxel writes the same slot
	// in the same cycle, so that sum is taken from the forwarding register instead.
	assign operand   = first_s2 ? '0 : (fwd_q ? fwd_sum_q : rdata_q);
	assign sum       = operand + SUM_W'(value_s2);
	assign fin_valid = valid_s2 && last_s2;
	assign fin_data  = {sum, tail_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			mem[slot_s2] <= sum;
		end
		if (pop) begin
			rdata_q   <= mem[q_slot];
			data_s2   <= q_data;
			fwd_sum_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
				fwd_q    <= adv && (q_slot == slot_s2);
			end else if (adv) begin
				valid_s2 <= 1'b0;
				fwd_q    <= 1'b0;
			end
		end
	end

	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> valid_s2)
		else $error("forwarded sum without a voxel in the accumulate stage");

endmodule

FILE: hdl/vbat_finish.sv
// Cube finisher: voxel count, threshold test, serial 8.8 average divide, result register.
// Depends on vbat_pkg and vbat_cube_if.
module vbat_finish import vbat_pkg::*; #(
	parameter int MAX_BLOCK = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [THR_W-1:0] threshold,
	input  logic in_valid,
	output logic in_ready,
	input  logic [SUM_W+3*COORD_W+3*$clog2(MAX_BLOCK+1)-1:0] in_data,
	vbat_cube_if.source cubes
);
	localparam int BLK_W = $clog2(MAX_BLOCK+1);
	localparam int CNT_W = 3*BLK_W;
	localparam int LIM_W = THR_W + CNT_W;
	localparam int CMP_W = (LIM_W > SUM_W) ? LIM_W : SUM_W;
	localparam int DVD_W = SUM_W + FRAC_W;
	localparam int IT_W  = $clog2(DVD_W);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_A, S_MUL_B, S_THRESH, S_CHECK, S_DIVIDE, S_DONE
	} state_t;

	state_t             state_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COORD_W-1:0] ox_q, oy_q, oz_q;
	logic [BLK_W-1:0]   cx_q, cy_q, cz_q;
	logic [2*BLK_W-1:0] pxy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LIM_W-1:0]   lim_q;
	logic [CNT_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q, quo_q;
	logic [IT_W-1:0]    iter_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [AVG_W-1:0]   out_avg_q;

	logic [SUM_W-1:0]   in_sum;
	logic [COORD_W-1:0] in_ox, in_oy, in_oz;
	logic [BLK_W-1:0]   in_cx, in_cy, in_cz;
	logic [CNT_W:0]     trial, trial_sub;
	logic               ge;

	assign {in_sum, in_ox, in_oy, in_oz, in_cx, in_cy, in_cz} = in_data;
	assign in_ready = state_q == S_IDLE;

	// One restoring division step per cycle; the remainder stays below the count.
	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, cnt_q};
	assign ge        = trial >= {1'b0, cnt_q};

	assign cubes.valid      = out_valid_q;
	assign cubes.origin_x   = out_x_q;
	assign cubes.origin_y   = out_y_q;
	assign cubes.origin_z   = out_z_q;
	assign cubes.average_q8 = out_avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			pxy_q       <= '0;
			cnt_q       <= '0;
			lim_q       <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			quo_q       <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_z_q     <= '0;
			out_avg_q   <= '0;
		end else begin
			// In S_DONE the result register is reloaded below instead of cleared.
			if (out_valid_q && cubes.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sum_q   <= in_sum;
						ox_q    <= in_ox;
						oy_q    <= in_oy;
						oz_q    <= in_oz;
						cx_q    <= in_cx;
						cy_q    <= in_cy;
						cz_q    <= in_cz;
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					pxy_q   <= (2*BLK_W)'(cx_q) * (2*BLK_W)'(cy_q);
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					cnt_q   <= CNT_W'(pxy_q) * CNT_W'(cz_q);
					state_q <= S_THRESH;
				end
				S_THRESH: begin
					lim_q   <= LIM_W'(threshold) * LIM_W'(cnt_q);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// Sum above threshold times count is the same as average above threshold.
					if (CMP_W'(sum_q) > CMP_W'(lim_q)) begin
						rem_q   <= '0;
						dvd_q   <= {sum_q, FRAC_W'(0)};
						quo_q   <= '0;
						iter_q  <= '0;
						state_q <= S_DIVIDE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIVIDE: begin
					rem_q  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
					dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
					quo_q  <= {quo_q[DVD_W-2:0], ge};
					iter_q <= iter_q + IT_W'(1);
					if (iter_q == IT_W'(DVD_W-1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || cubes.ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= ox_q;
						out_y_q     <= oy_q;
						out_z_q     <= oz_q;
						out_avg_q   <= quo_q[AVG_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVIDE) |-> (cnt_q != '0))
		else $error("average divide started with a zero voxel count");
	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVIDE) |-> (rem_q < cnt_q))
		else $error("division remainder not below the voxel count");

endmodule

FILE: hdl/voxel_block_average_threshold.sv
// Usage notes for voxel_block_average_threshold.
// Voxels of a 3D volume enter on the voxels channel one per transaction, x fastest,
// then y, then z. The volume is cut into cubes of block_factor voxels on a side,
// clipped at the far faces. When the last voxel of a cube arrives and the cube's
// average strictly exceeds threshold, one transaction on the cubes channel carries
// the cube origin and the average in unsigned 8.8 fixed point (rounded down).
// The user must write configuration through cfg_write_en/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Each write to a known
// register restarts the volume at the origin. Throughput: one voxel per cycle while
// no cube completes. A completing cube holds the finisher through its multiply,
// threshold and check states, and through the 28-step serial divider and the done
// state when it passes; a 4-entry queue absorbs voxels meanwhile. The result register
// is loaded in the done state.
// Reset clears counters, restores register defaults (128x128x128, block 4, threshold
// 0) and takes effect immediately; the sum slab needs no clearing because the first
// voxel of each cube overwrites its slot. A stalled receiver holds the result
// register; after that the finisher, the accumulator and the queue back up in turn,
// and the voxels channel then drops ready.
// Depends on vbat_pkg, vbat_if and the vbat_front/queue/accum/finish modules.
module voxel_block_average_threshold import vbat_pkg::*; #(
	parameter int MAX_SIDE  = 128,
	parameter int MAX_BLOCK = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	vbat_voxel_if.sink           voxels,
	vbat_cube_if.source          cubes
);
	localparam int SIDE_W = $clog2(MAX_SIDE+1);
	localparam int BLK_W  = $clog2(MAX_BLOCK+1);
	localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
	localparam int QW     = ADDR_W + 2 + VOXEL_W + 3*COORD_W + 3*BLK_W;
	localparam int FW     = SUM_W + 3*COORD_W + 3*BLK_W;

	logic [DIM_REG_W-1:0] width_q, height_q, depth_q;
	logic [BF_REG_W-1:0]  bf_q;
	logic [THR_W-1:0]     thr_q;

	logic              restart;
	logic [SIDE_W-1:0] side_w, side_h, side_d;
	logic [BLK_W-1:0]  bf;

	logic          push_valid, push_ready;
	logic [QW-1:0] push_data;
	logic          pop_valid, pop_ready;
	logic [QW-1:0] pop_data;
	logic          fin_valid, fin_ready;
	logic [FW-1:0] fin_data;

	function automatic logic [SIDE_W-1:0] eff_side(input logic [DIM_REG_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end
		if (int'(v) > MAX_SIDE) begin
			return SIDE_W'(MAX_SIDE);
		end
		return SIDE_W'(v);
	endfunction

	assign side_w = eff_side(width_q);
	assign side_h = eff_side(height_q);
	assign side_d = eff_side(depth_q);
	assign bf = (bf_q == '0) ? BLK_W'(1)
		: ((int'(bf_q) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : BLK_W'(bf_q));

	assign restart = cfg_write_en && (cfg_index inside {[REG_GRID_WIDTH:REG_THRESHOLD]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			depth_q  <= DIM_RESET;
			bf_q     <= BF_RESET;
			thr_q    <= THR_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_GRID_WIDTH:   width_q  <= cfg_data;
				REG_GRID_HEIGHT:  height_q <= cfg_data;
				REG_GRID_DEPTH:   depth_q  <= cfg_data;
				REG_BLOCK_FACTOR: bf_q     <= cfg_data[BF_REG_W-1:0];
				REG_THRESHOLD:    thr_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vbat_front #(
		.MAX_SIDE  (MAX_SIDE),
		.MAX_BLOCK (MAX_BLOCK)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.side_w     (side_w),
		.side_h     (side_h),
		.side_d     (side_d),
		.bf         (bf),
		.voxels     (voxels),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	vbat_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	vbat_accum #(
		.MAX_SIDE  (MAX_SIDE),
		.MAX_BLOCK (MAX_BLOCK)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_data    (pop_data),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_data  (fin_data)
	);

	vbat_finish #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (thr_q),
		.in_valid  (fin_valid),
		.in_ready  (fin_ready),
		.in_data   (fin_data),
		.cubes     (cubes)
	);

endmodule
